FILE: rtl/bresenham_line_rasterizer_assert.svh
// assertion macros for the line rasterizer checker
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("line rasterizer assertion failed");

// next-cycle implication, disabled while in reset
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("line rasterizer assertion failed");

`endif

FILE: rtl/blr_pkg.sv
// types and constants shared by the line rasterizer files
`default_nettype none

package blr_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  localparam int unsigned DEC_BITS   = COORD_BITS + 4;
  localparam int unsigned COLOR_BITS = 8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last_pixel;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/bresenham_line_rasterizer.sv
// A pixel passes through the input register and then the result register before it is offered.
// Throughput: one item per cycle unless a held-back result stalls the input; a load and each step
// cost one pass through the input register, the setup or step adder stage and the result register.
// A step while idle gives no pixel and still passes through the input register.
// Reset (asynchronous, active low) empties both registers and clears the line state.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire blr_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output blr_pkg::out_item_t     out_data_o
);

  localparam int unsigned CB = blr_pkg::COORD_BITS;
  localparam int unsigned EB = blr_pkg::DIFF_BITS;
  localparam int unsigned DB = blr_pkg::DEC_BITS;

  // input register
  logic              s1_valid_q;
  blr_pkg::in_item_t s1_data_q;

  // result register
  logic               out_valid_q;
  blr_pkg::out_item_t out_data_q;

  // line state
  logic                          active_q, active_d;
  logic signed [CB-1:0]          cur_x_q, cur_x_d;
  logic signed [CB-1:0]          cur_y_q, cur_y_d;
  logic signed [CB-1:0]          major_end_q, major_end_d;
  logic signed [DB-1:0]          decision_q, decision_d;
  logic signed [DB-1:0]          incr_straight_q, incr_straight_d;
  logic signed [DB-1:0]          incr_up_q, incr_up_d;
  logic signed [DB-1:0]          incr_down_q, incr_down_d;
  logic                          major_is_y_q, major_is_y_d;
  logic                          minor_falls_q, minor_falls_d;
  logic [blr_pkg::COLOR_BITS-1:0] line_color_q, line_color_d;

  logic               produces;
  logic               advance;
  logic               last_d;

  // setup path signals
  logic signed [EB-1:0] dx, dy, adx, ady, dmin_sel, dmin, dmaj;
  logic                 ld_major_is_y, ld_swap;
  logic signed [DB-1:0] dmin_w, dmaj_w;

  // step path signals
  logic                 dec_le0;
  logic signed [CB-1:0] minor_step;
  logic signed [CB-1:0] step_x, step_y, step_major;

  // handshake
  assign produces   = (s1_data_q.mode == blr_pkg::MODE_LOAD) || active_q;
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i || !produces);
  assign in_stall_o = s1_valid_q && !advance;

  // load setup: axis choice, ordering and the major and minor differences
  always_comb begin
    dx  = EB'(s1_data_q.end_x) - EB'(s1_data_q.start_x);
    dy  = EB'(s1_data_q.end_y) - EB'(s1_data_q.start_y);
    adx = dx[EB-1] ? -dx : dx;
    ady = dy[EB-1] ? -dy : dy;
    ld_major_is_y = !(adx > ady);
    ld_swap  = ld_major_is_y ? dy[EB-1] : dx[EB-1];
    dmaj     = ld_major_is_y ? ady : adx;
    dmin_sel = ld_major_is_y ? dx : dy;
    dmin     = ld_swap ? -dmin_sel : dmin_sel;
    dmin_w   = DB'(dmin);
    dmaj_w   = DB'(dmaj);
  end

  // step: decision sign picks the minor move
  always_comb begin
    dec_le0 = decision_q[DB-1] || (decision_q == '0);
    if (!minor_falls_q) begin
      minor_step = dec_le0 ? CB'(0) : CB'(1);
    end else begin
      minor_step = dec_le0 ? -CB'(1) : CB'(0);
    end
    if (major_is_y_q) begin
      step_y = cur_y_q + CB'(1);
      step_x = cur_x_q + minor_step;
      step_major = step_y;
    end else begin
      step_x = cur_x_q + CB'(1);
      step_y = cur_y_q + minor_step;
      step_major = step_x;
    end
  end

  // next line state and last flag
  always_comb begin
    active_d        = active_q;
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    major_end_d     = major_end_q;
    decision_d      = decision_q;
    incr_straight_d = incr_straight_q;
    incr_up_d       = incr_up_q;
    incr_down_d     = incr_down_q;
    major_is_y_d    = major_is_y_q;
    minor_falls_d   = minor_falls_q;
    line_color_d    = line_color_q;
    last_d          = 1'b0;
    case (s1_data_q.mode)
      blr_pkg::MODE_LOAD: begin
        major_is_y_d    = ld_major_is_y;
        minor_falls_d   = dmin[EB-1];
        decision_d      = dmin[EB-1] ? (dmin_w + dmin_w + dmaj_w) : (dmin_w + dmin_w - dmaj_w);
        incr_up_d       = (dmin_w - dmaj_w) + (dmin_w - dmaj_w);
        incr_straight_d = dmin_w + dmin_w;
        incr_down_d     = (dmin_w + dmaj_w) + (dmin_w + dmaj_w);
        cur_x_d         = ld_swap ? s1_data_q.end_x : s1_data_q.start_x;
        cur_y_d         = ld_swap ? s1_data_q.end_y : s1_data_q.start_y;
        if (ld_major_is_y) begin
          major_end_d = ld_swap ? s1_data_q.start_y : s1_data_q.end_y;
        end else begin
          major_end_d = ld_swap ? s1_data_q.start_x : s1_data_q.end_x;
        end
        line_color_d    = s1_data_q.color;
        last_d          = (dmaj == '0);
        active_d        = !last_d;
      end
      blr_pkg::MODE_STEP: begin
        if (dec_le0 != minor_falls_q) begin
          decision_d = decision_q + incr_straight_q;
        end else if (minor_falls_q) begin
          decision_d = decision_q + incr_down_q;
        end else begin
          decision_d = decision_q + incr_up_q;
        end
        cur_x_d  = step_x;
        cur_y_d  = step_y;
        last_d   = (step_major >= major_end_q);
        active_d = !last_d;
      end
      default: begin
        last_d = 1'b0;
      end
    endcase
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_data_q.pixel_x     <= cur_x_d;
      out_data_q.pixel_y     <= cur_y_d;
      out_data_q.pixel_color <= line_color_d;
      out_data_q.last_pixel  <= last_d;
    end
  end

  // line state update on every transfer that makes a pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q        <= 1'b0;
      cur_x_q         <= '0;
      cur_y_q         <= '0;
      major_end_q     <= '0;
      decision_q      <= '0;
      incr_straight_q <= '0;
      incr_up_q       <= '0;
      incr_down_q     <= '0;
      major_is_y_q    <= 1'b0;
      minor_falls_q   <= 1'b0;
      line_color_q    <= '0;
    end else if (advance && produces) begin
      active_q        <= active_d;
      cur_x_q         <= cur_x_d;
      cur_y_q         <= cur_y_d;
      major_end_q     <= major_end_d;
      decision_q      <= decision_d;
      incr_straight_q <= incr_straight_d;
      incr_up_q       <= incr_up_d;
      incr_down_q     <= incr_down_d;
      major_is_y_q    <= major_is_y_d;
      minor_falls_q   <= minor_falls_d;
      line_color_q    <= line_color_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/blr_checker.sv
// port-level checker for the line rasterizer, bound to the top level
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module blr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire blr_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire blr_pkg::out_item_t out_data_o
);

  // a stalled result stays offered
  `BLR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `BLR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // input side only stalls while a result is held back
  `BLR_ASSERT_NOW(a_no_idle_stall, clk_i, rst_ni, !out_valid_o || !out_stall_i, !in_stall_o)

  // a load transfer always yields a pixel through the input and result registers when not held back
  `BLR_ASSERT_NEXT(a_load_pixel, clk_i, rst_ni, (in_valid_i && !in_stall_o && (in_data_i.mode == blr_pkg::MODE_LOAD)) ##1 !out_stall_i, out_valid_o)

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

`default_nettype wire
